// ===== design/pacp_pkg.sv =====
// shared types and constants for the polygon area, perimeter and centroid block
// no dependencies
package pacp_pkg;

  localparam int unsigned DefMaxVertices = 4096;
  localparam int unsigned CoordW         = 16;
  localparam int unsigned ScaleW         = 16;
  localparam int unsigned AreaW          = 48;
  localparam int unsigned PerimW         = 40;
  localparam int unsigned TotalW         = 13;
  localparam int unsigned DiffW          = CoordW + 1;
  localparam int unsigned ProdW          = 2 * DiffW;
  localparam int unsigned SqW            = ProdW;
  localparam int unsigned RootW          = SqW / 2;
  localparam int unsigned RemW           = RootW + 2;
  localparam int unsigned QueueDepth     = 2;
  localparam logic [ScaleW-1:0] ScaleReset = 16'd256;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     final_vertex;
  } vertex_t;

  typedef struct packed {
    logic [AreaW-1:0]         area_scaled;
    logic [PerimW-1:0]        perimeter_scaled;
    logic signed [CoordW-1:0] centroid_x;
    logic signed [CoordW-1:0] centroid_y;
    logic [TotalW-1:0]        vertex_total;
  } result_t;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_EDGE,
    OP_SKIP
  } op_e;

  typedef struct packed {
    op_e     op;
    vertex_t vtx;
  } cmd_t;

endpackage

// ===== design/pacp_front.sv =====
// front part: accepts vertex items, classifies them and queues commands
// depends on pacp_pkg
module pacp_front import pacp_pkg::*; #(
  parameter int unsigned MaxVertices = DefMaxVertices
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  vertex_t in_data_i,
  output logic    cmd_valid_o,
  input  logic    cmd_ready_i,
  output cmd_t    cmd_o
);

  localparam int unsigned CntW = $clog2(MaxVertices + 1);
  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            q_mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;
  cmd_t            cmd_new;

  assign in_ready_o  = (fill_q != (PtrW + 1)'(QueueDepth));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // classify against the running vertex count of the open polygon
  always_comb begin
    cmd_new.vtx = in_data_i;
    if (cnt_q == '0) begin
      cmd_new.op = OP_FIRST;
    end else if (cnt_q < CntW'(MaxVertices)) begin
      cmd_new.op = OP_EDGE;
    end else begin
      cmd_new.op = OP_SKIP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
        if (in_data_i.final_vertex) begin
          cnt_q <= '0;
        end else if (cmd_new.op != OP_SKIP) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/pacp_back.sv =====
// back part: edge arithmetic, square root, scaling, centroid division, result register
// depends on pacp_pkg
module pacp_back import pacp_pkg::*; #(
  parameter int unsigned MaxVertices = DefMaxVertices
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  input  logic [ScaleW-1:0] scale_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_data_o
);

  localparam int unsigned CntW     = $clog2(MaxVertices + 1);
  localparam int unsigned SumW     = CoordW + CntW;
  localparam int unsigned CrossW   = 2 * CoordW + CntW;
  localparam int unsigned LenW     = RootW + 1 + CntW;
  localparam int unsigned AreaAccW = (CrossW + ScaleW > AreaW + 1) ? CrossW + ScaleW : AreaW + 1;
  localparam int unsigned PerAccW  = (LenW + ScaleW > PerimW + 1) ? LenW + ScaleW : PerimW + 1;
  localparam int unsigned StepW    = $clog2(SumW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLOSE = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]               state_q;
  logic [StepW-1:0]         step_q;
  logic                     closing_q, pend_q;
  logic signed [CoordW-1:0] fx_q, fy_q, px_q, py_q, ax_q, ay_q, bx_q, by_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [SumW-1:0]   sumx_q, sumy_q;
  logic signed [CrossW-1:0] cross_q;
  logic [LenW-1:0]          len_q;
  logic signed [ProdW-1:0]  prod_q, cterm_q;
  logic [SqW-1:0]           sq_q;
  logic [RemW-1:0]          rem_q;
  logic [RootW-1:0]         root_q;
  logic [AreaAccW-1:0]      mcand_q, aacc_q;
  logic [PerAccW-1:0]       pcand_q, pacc_q;
  logic [ScaleW-1:0]        sc_q;
  logic [SumW-1:0]          dmx_q, dmy_q;
  logic [CntW-1:0]          rx_q, ry_q;
  logic                     negx_q, negy_q;
  logic                     out_valid_q;
  result_t                  out_q;

  logic signed [DiffW-1:0]  dx, dy, ma, mb;
  logic signed [ProdW-1:0]  mul;
  logic [RemW+1:0]          rtrial, trial;
  logic [RootW-1:0]         root_nx;
  logic [RemW-1:0]          rem_nx;
  logic [LenW-1:0]          len_nx;
  logic [CrossW-1:0]        mag;
  logic [CntW:0]            rxs, rys;
  logic                     qx, qy;
  logic [AreaAccW-1:0]      ahalf;
  logic [SumW-1:0]          qxs, qys;
  logic                     out_load;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // one shared signed multiplier, operands picked by step
  assign dx = DiffW'(bx_q) - DiffW'(ax_q);
  assign dy = DiffW'(by_q) - DiffW'(ay_q);
  always_comb begin
    case (step_q)
      StepW'(0): begin ma = dx; mb = dx; end
      StepW'(1): begin ma = dy; mb = dy; end
      StepW'(2): begin ma = DiffW'(ax_q); mb = DiffW'(by_q); end
      StepW'(3): begin ma = DiffW'(ay_q); mb = DiffW'(bx_q); end
      default:   begin ma = dx; mb = dx; end
    endcase
  end
  assign mul = ma * mb;

  // restoring square root, two radicand bits a step
  assign rtrial = {rem_q, sq_q[SqW-1 -: 2]};
  assign trial  = (RemW + 2)'({root_q, 2'b01});
  always_comb begin
    if (rtrial >= trial) begin
      rem_nx  = RemW'(rtrial - trial);
      root_nx = {root_q[RootW-2:0], 1'b1};
    end else begin
      rem_nx  = RemW'(rtrial);
      root_nx = {root_q[RootW-2:0], 1'b0};
    end
  end
  assign len_nx = len_q + LenW'(root_nx);
  assign mag    = cross_q[CrossW-1] ? $unsigned(-cross_q) : $unsigned(cross_q);

  // restoring division of both coordinate sums by the count
  assign rxs = {rx_q, dmx_q[SumW-1]};
  assign rys = {ry_q, dmy_q[SumW-1]};
  assign qx  = (rxs >= {1'b0, cnt_q});
  assign qy  = (rys >= {1'b0, cnt_q});
  assign qxs = negx_q ? (~dmx_q + 1'b1) : dmx_q;
  assign qys = negy_q ? (~dmy_q + 1'b1) : dmy_q;
  assign ahalf = aacc_q >> 1;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          ax_q <= px_q;
          ay_q <= py_q;
          bx_q <= cmd_i.vtx.vertex_x;
          by_q <= cmd_i.vtx.vertex_y;
        end
      end
      ST_CLOSE: begin
        ax_q <= px_q;
        ay_q <= py_q;
        bx_q <= fx_q;
        by_q <= fy_q;
      end
      ST_MUL: begin
        prod_q <= mul;
        case (step_q)
          StepW'(1): sq_q <= SqW'($unsigned(prod_q));
          StepW'(2): sq_q <= sq_q + SqW'($unsigned(prod_q));
          StepW'(3): cterm_q <= prod_q;
          default: ;
        endcase
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        rem_q  <= rem_nx;
        root_q <= root_nx;
        sq_q   <= sq_q << 2;
        mcand_q <= AreaAccW'(mag);
        pcand_q <= PerAccW'(len_nx);
        sc_q    <= scale_i;
        aacc_q  <= '0;
        pacc_q  <= '0;
      end
      ST_SCALE: begin
        if (sc_q[0]) begin
          aacc_q <= aacc_q + mcand_q;
          pacc_q <= pacc_q + pcand_q;
        end
        mcand_q <= mcand_q << 1;
        pcand_q <= pcand_q << 1;
        sc_q    <= sc_q >> 1;
        negx_q  <= sumx_q[SumW-1];
        negy_q  <= sumy_q[SumW-1];
        dmx_q   <= sumx_q[SumW-1] ? $unsigned(-sumx_q) : $unsigned(sumx_q);
        dmy_q   <= sumy_q[SumW-1] ? $unsigned(-sumy_q) : $unsigned(sumy_q);
        rx_q    <= '0;
        ry_q    <= '0;
      end
      ST_DIV: begin
        rx_q  <= qx ? CntW'(rxs - {1'b0, cnt_q}) : CntW'(rxs);
        ry_q  <= qy ? CntW'(rys - {1'b0, cnt_q}) : CntW'(rys);
        dmx_q <= {dmx_q[SumW-2:0], qx};
        dmy_q <= {dmy_q[SumW-2:0], qy};
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.area_scaled      <= (ahalf > AreaAccW'({AreaW{1'b1}})) ? {AreaW{1'b1}}
                                                                   : ahalf[AreaW-1:0];
      out_q.perimeter_scaled <= (pacc_q > PerAccW'({PerimW{1'b1}})) ? {PerimW{1'b1}}
                                                                     : pacc_q[PerimW-1:0];
      out_q.centroid_x       <= $signed(qxs[CoordW-1:0]);
      out_q.centroid_y       <= $signed(qys[CoordW-1:0]);
      out_q.vertex_total     <= TotalW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      closing_q   <= 1'b0;
      pend_q      <= 1'b0;
      fx_q        <= '0;
      fy_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      cnt_q       <= '0;
      sumx_q      <= '0;
      sumy_q      <= '0;
      cross_q     <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces a taken one in the same cycle
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_FIRST: begin
                fx_q   <= cmd_i.vtx.vertex_x;
                fy_q   <= cmd_i.vtx.vertex_y;
                px_q   <= cmd_i.vtx.vertex_x;
                py_q   <= cmd_i.vtx.vertex_y;
                sumx_q <= SumW'(cmd_i.vtx.vertex_x);
                sumy_q <= SumW'(cmd_i.vtx.vertex_y);
                cnt_q  <= CntW'(1);
                if (cmd_i.vtx.final_vertex) begin
                  state_q <= ST_CLOSE;
                end
              end
              OP_EDGE: begin
                px_q    <= cmd_i.vtx.vertex_x;
                py_q    <= cmd_i.vtx.vertex_y;
                sumx_q  <= sumx_q + SumW'(cmd_i.vtx.vertex_x);
                sumy_q  <= sumy_q + SumW'(cmd_i.vtx.vertex_y);
                cnt_q   <= cnt_q + 1'b1;
                pend_q  <= cmd_i.vtx.final_vertex;
                state_q <= ST_MUL;
              end
              default: begin
                if (cmd_i.vtx.final_vertex) begin
                  state_q <= ST_CLOSE;
                end
              end
            endcase
          end
        end
        ST_CLOSE: begin
          closing_q <= 1'b1;
          pend_q    <= 1'b0;
          step_q    <= '0;
          state_q   <= ST_MUL;
        end
        ST_MUL: begin
          if (step_q == StepW'(4)) begin
            cross_q <= cross_q + CrossW'(cterm_q) - CrossW'(prod_q);
            step_q  <= '0;
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_SQRT: begin
          if (step_q == StepW'(RootW - 1)) begin
            len_q  <= len_nx;
            step_q <= '0;
            if (closing_q) begin
              state_q <= ST_SCALE;
            end else if (pend_q) begin
              state_q <= ST_CLOSE;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_SCALE: begin
          if (step_q == StepW'(ScaleW - 1)) begin
            step_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (step_q == StepW'(SumW - 1)) begin
            step_q  <= '0;
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            closing_q   <= 1'b0;
            cnt_q       <= '0;
            sumx_q      <= '0;
            sumy_q      <= '0;
            cross_q     <= '0;
            len_q       <= '0;
            fx_q        <= '0;
            fy_q        <= '0;
            px_q        <= '0;
            py_q        <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/polygon_area_perimeter_centroid_top.sv =====
// top level of the shoelace polygon area, perimeter and centroid block
// depends on pacp_pkg, pacp_front and pacp_back
//
// vertices arrive one item at a time in signed q11.4; the item flagged final_vertex
// closes the polygon and one result item follows with the scaled area, the scaled
// perimeter (closing edge included), the centroid and the vertex count. a front
// part takes items into a two-entry command queue, tagging each as first vertex,
// edge or ignored (beyond MAX_VERTICES), so the upstream side can run ahead while
// the back part works, until the queue fills. the back part takes one vertex at
// a time, only from idle: a single shared 17x17 multiplier forms the squared edge
// and the cross term, then a two-bits-a-step square root forms the edge length.
// closing costs one more edge, then shift-and-add scaling by the scale factor and
// restoring division of the coordinate sums by the vertex count for the centroid.
// the result sits in an output register so a stalled consumer does not stop the
// queue filling. scale_factor is q8.8 (reset 1.0) and should only be written
// while no polygon is in flight
module polygon_area_perimeter_centroid_top import pacp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DefMaxVertices
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vertex_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_data_o,
  input  logic              cfg_we_i,
  input  logic [ScaleW-1:0] cfg_wdata_i
);

  logic [ScaleW-1:0] scale_q;
  logic              cmd_valid, cmd_ready;
  cmd_t              cmd;

  // scale register, kept across polygons
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // accept and classify items
  pacp_front #(
    .MaxVertices (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // edge arithmetic and polygon close
  pacp_back #(
    .MaxVertices (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .scale_i     (scale_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/pacp_checker.sv =====
// port-level checks for the polygon block, bound to the top level
// depends on pacp_pkg and polygon_area_perimeter_centroid_top
module pacp_checker import pacp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input vertex_t           in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input result_t           out_data_o,
  input logic              cfg_we_i,
  input logic [ScaleW-1:0] cfg_wdata_i
);

  // a waiting vertex item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("vertex item changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a lone vertex has no area and no perimeter
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.vertex_total == TotalW'(1)) |->
      (out_data_o.area_scaled == '0) && (out_data_o.perimeter_scaled == '0))
    else $error("single vertex gave nonzero area or perimeter");

  // two vertices enclose no area
  a_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.vertex_total == TotalW'(2)) |->
      (out_data_o.area_scaled == '0))
    else $error("two vertices gave nonzero area");

  // scale writes carry known data
  a_cfg_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !$isunknown(cfg_wdata_i))
    else $error("scale write with unknown data");

endmodule

bind polygon_area_perimeter_centroid_top pacp_checker u_pacp_checker (.*);
